// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell #(
  parameter int PRIO_BITS = 8,
  parameter int TAG_BITS  = 16
) (
  input  logic                   clk,
  input  spq_pkg::cell_ctrl_t    ctrl,
  input  logic                   occ,
  input  logic [PRIO_BITS-1:0]   new_prio,
  input  logic [TAG_BITS-1:0]    new_tag,
  input  logic [PRIO_BITS-1:0]   left_prio,
  input  logic [TAG_BITS-1:0]    left_tag,
  input  logic                   left_gt,
  input  logic                   left_take,
  input  logic [PRIO_BITS-1:0]   right_prio,
  input  logic [TAG_BITS-1:0]    right_tag,
  output logic                   gt,
  output logic                   take,
  output logic [PRIO_BITS-1:0]   prio,
  output logic [TAG_BITS-1:0]    tag
);

  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;

  // held entry is pushed right when its priority is strictly greater
  assign gt   = occ && (prio_r > new_prio);
  assign take = !occ || gt;
  assign prio = prio_r;
  assign tag  = tag_r;

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end else if (take && !left_take) begin
        prio_nxt = new_prio;
        tag_nxt  = new_tag;
      end
    end else if (ctrl.rem) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

// ===== src/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// an accepted item's result is registered and shown on out_tvalid in the cycle after it is taken
// throughput: one item per cycle while results are taken; the row of cells
// compares all held entries against the new one and shifts them as the item is accepted
// reset: clears the fill count and the output valid; entry contents stay
// undefined and are never read beyond the fill count

module stable_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8,
  parameter int TAG_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((PRIO_BITS+TAG_BITS+7)/8)*8-1:0] in_tdata,  // prio, tag
  input  logic                                   in_tuser,  // kind
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // status, served_tag, served_prio, occupancy
  output logic [((spq_pkg::STATUS_BITS+TAG_BITS+PRIO_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                                 out_tdata,
  output logic                                   out_tuser  // served_valid
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RES_W = spq_pkg::STATUS_BITS + TAG_BITS + PRIO_BITS + CW;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic [PRIO_BITS-1:0] new_prio;
  logic [TAG_BITS-1:0]  new_tag;
  logic                 accept, full, empty;
  spq_pkg::cell_ctrl_t  ctrl;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;

  spq_pkg::status_t     status_r, status_nxt;
  logic                 served_valid_r, served_valid_nxt;
  logic [TAG_BITS-1:0]  served_tag_r, served_tag_nxt;
  logic [PRIO_BITS-1:0] served_prio_r, served_prio_nxt;

  logic [DEPTH-1:0]     occ, gt, take;
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag  [DEPTH];

  assign new_prio  = in_tdata[PRIO_BITS-1:0];
  assign new_tag   = in_tdata[PRIO_BITS+TAG_BITS-1:PRIO_BITS];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctrl.ins = accept && (in_tuser == spq_pkg::KIND_INSERT) && !full;
  assign ctrl.rem = accept && (in_tuser == spq_pkg::KIND_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                 l_gt, l_take;
      logic [PRIO_BITS-1:0] l_prio, r_prio;
      logic [TAG_BITS-1:0]  l_tag, r_tag;

      assign occ[i] = (count_r > CW'(i));

      if (i == 0) begin : g_first
        assign l_gt   = 1'b0;
        assign l_take = 1'b0;
        assign l_prio = new_prio;
        assign l_tag  = new_tag;
      end else begin : g_mid
        assign l_gt   = gt[i-1];
        assign l_take = take[i-1];
        assign l_prio = cell_prio[i-1];
        assign l_tag  = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_prio = cell_prio[i];
        assign r_tag  = cell_tag[i];
      end else begin : g_inner
        assign r_prio = cell_prio[i+1];
        assign r_tag  = cell_tag[i+1];
      end

      spq_cell #(
        .PRIO_BITS(PRIO_BITS),
        .TAG_BITS (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[i]),
        .new_prio  (new_prio),
        .new_tag   (new_tag),
        .left_prio (l_prio),
        .left_tag  (l_tag),
        .left_gt   (l_gt),
        .left_take (l_take),
        .right_prio(r_prio),
        .right_tag (r_tag),
        .gt        (gt[i]),
        .take      (take[i]),
        .prio      (cell_prio[i]),
        .tag       (cell_tag[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt        = count_r;
    status_nxt       = spq_pkg::ST_OK;
    served_valid_nxt = 1'b0;
    served_tag_nxt   = '0;
    served_prio_nxt  = '0;
    if (in_tuser == spq_pkg::KIND_INSERT) begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        count_nxt        = count_r - CW'(1);
        served_valid_nxt = 1'b1;
        served_tag_nxt   = cell_tag[0];
        served_prio_nxt  = cell_prio[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r       <= status_nxt;
      served_valid_r <= served_valid_nxt;
      served_tag_r   <= served_tag_nxt;
      served_prio_r  <= served_prio_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = served_valid_r;
  assign out_tdata  = OUT_W'({count_r, served_prio_r, served_tag_r, status_r});

endmodule
